### hw/rtl/oesc_pkg.sv
// Shared constants, codes and types of the one-edit spell checker.
`default_nettype none
package oesc_pkg;

   // Sizing
   localparam int DICT_DEPTH = 64;
   localparam int MAX_LEN    = 16;
   localparam int ALPHABET   = 26;
   localparam int LETTER_W   = 5;
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int IDX_W      = $clog2(DICT_DEPTH);
   localparam int CNT_W      = $clog2(DICT_DEPTH + 1);
   localparam int ROW_W      = MAX_LEN * LETTER_W + LEN_W;

   // Item kinds on the request side
   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Result codes
   typedef enum logic [2:0] {
      STAT_CORRECT = 3'd0,
      STAT_SUGGEST = 3'd1,
      STAT_NOMATCH = 3'd2,
      STAT_STORED  = 3'd3,
      STAT_REJECT  = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_RESULT
   } state_type;

   typedef logic [MAX_LEN-1:0][LETTER_W-1:0] letters_type;

   // Compare unit verdict for one dictionary entry
   typedef struct packed {
      logic exact;
      logic near;
   } match_type;

endpackage
`default_nettype wire

### hw/rtl/oesc_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module oesc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/oesc_match.sv
// Compare unit: classifies one dictionary entry against the query word.
`default_nettype none
module oesc_match (
   input  wire oesc_pkg::letters_type                q_letters,
   input  wire logic [oesc_pkg::LEN_W-1:0]           q_len,
   input  wire oesc_pkg::letters_type                b_letters,
   input  wire logic [oesc_pkg::LEN_W-1:0]           b_len,
   output oesc_pkg::match_type                       result
);

   localparam int N = oesc_pkg::MAX_LEN;

   logic [N-1:0] eq0;     // q[i] == b[i]
   logic [N-1:0] sh_q;    // q[i+1] == b[i]  (query has the extra letter)
   logic [N-1:0] sh_b;    // b[i+1] == q[i]  (entry has the extra letter)
   logic [N-1:0] in_q;    // i < q_len
   logic [N-1:0] in_b;    // i < b_len
   logic [N-1:0] b_alpha; // b[i] is a real letter
   logic [N:0]   pre;     // all positions below i match
   logic [N-1:0] diff;
   logic [N-1:0] pos;
   logic         len_eq;
   logic         len_ins;
   logic         len_del;
   logic         sub_ok;
   logic         ins_ok;
   logic         del_ok;
   logic         bp_ok;

   // Per-position compares
   always_comb begin
      for (int i = 0; i < N; i++) begin
         eq0[i]     = (q_letters[i] == b_letters[i]);
         in_q[i]    = (oesc_pkg::LEN_W'(i) < q_len);
         in_b[i]    = (oesc_pkg::LEN_W'(i) < b_len);
         b_alpha[i] = (b_letters[i] < oesc_pkg::LETTER_W'(oesc_pkg::ALPHABET));
         if (i < N - 1) begin
            sh_q[i] = (q_letters[i+1] == b_letters[i]);
            sh_b[i] = (b_letters[i+1] == q_letters[i]);
         end else begin
            sh_q[i] = 1'b0;
            sh_b[i] = 1'b0;
         end
      end
   end

   // Matching prefix
   always_comb begin
      pre[0] = 1'b1;
      for (int i = 0; i < N; i++) begin
         pre[i+1] = pre[i] & eq0[i];
      end
   end

   // Edit checks
   always_comb begin
      diff   = in_q & ~eq0;
      len_eq  = (q_len == b_len);
      len_ins = (q_len == b_len + oesc_pkg::LEN_W'(1));
      len_del = (q_len + oesc_pkg::LEN_W'(1) == b_len);
      sub_ok = (diff != '0) && ((diff & (diff - N'(1))) == '0) && ((diff & b_alpha) != '0);
      ins_ok = 1'b1;
      del_ok = 1'b1;
      for (int i = 0; i < N; i++) begin
         if (in_b[i] && !pre[i+1] && !sh_q[i]) ins_ok = 1'b0;
         if (in_q[i] && !pre[i+1] && !sh_b[i]) del_ok = 1'b0;
         // first mismatch, or the end of the query
         pos[i] = pre[i] & ((in_q[i] & ~eq0[i]) | (oesc_pkg::LEN_W'(i) == q_len));
      end
      bp_ok = ((pos & b_alpha) != '0);
   end

   assign result.exact = len_eq & (diff == '0);
   assign result.near  = (len_eq & sub_ok) | (len_ins & ins_ok) | (len_del & del_ok & bp_ok);

endmodule
`default_nettype wire

### hw/rtl/one_edit_spell_checker.sv
// Top level: word collection, dictionary store and the query sequencer.
//
// Usage: words enter one letter per item on the req_ channel. req_tuser gives
// the kind (load letter, query letter, clear, ignored), req_tdata the letter
// and req_tlast marks the final letter of a word. Results leave on the rsp_
// channel: rsp_tuser is the status, rsp_tdata the entry index and rsp_tlast
// flags the final result of an item.
// Letters without req_tlast and clear items give no result.
// A finished load (stored or rejected) or an overlong word gives its result
// from the output register, loaded when the item is accepted.
// A finished query scans the dictionary through one shared compare unit, one
// entry per cycle from a registered-read RAM. An exact hit stops the scan
// early. Suggestions are then walked from a hit mask, one entry index per
// cycle unless a stall on rsp_tready holds the walk. req_tready is low while
// a query runs.
// Results sit in one output register; a stall on rsp_tready holds the
// sequencer and the request side until the result is taken.
// Reset empties the dictionary count and the word buffer; store contents need
// no clearing since only written entries are read.
`default_nettype none
module one_edit_spell_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   // request
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // [4:0] letter
   input  wire logic [1:0] req_tuser,  // [1:0] action
   input  wire logic       req_tlast,  // word_end
   // result
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,  // [5:0] entry_index
   output logic      [2:0] rsp_tuser,  // [2:0] status
   output logic            rsp_tlast   // last
);

   localparam int LW  = oesc_pkg::LEN_W;
   localparam int IW  = oesc_pkg::IDX_W;
   localparam int CW  = oesc_pkg::CNT_W;
   localparam int DD  = oesc_pkg::DICT_DEPTH;
   localparam int ML  = oesc_pkg::MAX_LEN;
   localparam int LTW = oesc_pkg::LETTER_W;

   oesc_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]         entry_count_ff, entry_count_in;
   oesc_pkg::letters_type word_buf_ff, word_buf_in;
   logic [LW-1:0]         word_len_ff, word_len_in;
   logic                  overlong_ff, overlong_in;
   logic [LW-1:0]         qlen_ff, qlen_in;
   logic [CW-1:0]         scan_ptr_ff, scan_ptr_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [DD-1:0]         hit_mask_ff, hit_mask_in;
   logic [IW-1:0]         emit_idx_ff, emit_idx_in;
   oesc_pkg::status_type  res_status_ff, res_status_in;
   logic [IW-1:0]         res_index_ff, res_index_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   oesc_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [IW-1:0]         rsp_index_ff, rsp_index_in;
   logic                  rsp_last_ff, rsp_last_in;

   oesc_pkg::action_type  act;
   oesc_pkg::letters_type row_letters;
   oesc_pkg::letters_type b_letters;
   oesc_pkg::match_type   verdict;
   logic [LTW-1:0]        letter;
   logic [oesc_pkg::ROW_W-1:0] wr_row;
   logic [oesc_pkg::ROW_W-1:0] rd_row;
   logic [LW-1:0]         b_len;
   logic [DD-1:0]         mask_rest;
   logic                  out_free;
   logic                  in_fire;
   logic                  is_letter;
   logic                  room;
   logic                  word_fin;
   logic                  final_over;
   logic                  dict_full;
   logic                  store_en;
   logic                  issue;
   logic                  hit_exact;
   logic                  scan_done;
   logic                  emit_bit;

   // Handshake and item decode
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == oesc_pkg::ST_IDLE) && out_free;
   assign in_fire    = req_tvalid && req_tready;
   assign act        = oesc_pkg::action_type'(req_tuser);
   assign letter     = req_tdata[LTW-1:0];
   assign is_letter  = (act == oesc_pkg::ACT_LOAD) || (act == oesc_pkg::ACT_QUERY);
   assign room       = (word_len_ff < LW'(ML));
   assign word_fin   = in_fire && is_letter && req_tlast;
   assign final_over = overlong_ff || !room;
   assign dict_full  = (entry_count_ff == CW'(DD));
   assign store_en   = word_fin && (act == oesc_pkg::ACT_LOAD) && !final_over && !dict_full;

   // Word buffer with the incoming letter appended
   always_comb begin
      for (int i = 0; i < ML; i++) begin
         row_letters[i] = (LW'(i) == word_len_ff) ? letter : word_buf_ff[i];
      end
   end

   assign wr_row = {LW'(word_len_ff + LW'(1)), row_letters};

   // Scan control
   assign issue     = (state_ff == oesc_pkg::ST_SCAN) && (scan_ptr_ff < entry_count_ff);
   assign b_letters = rd_row[ML*LTW-1:0];
   assign b_len     = rd_row[oesc_pkg::ROW_W-1 -: LW];
   assign hit_exact = cmp_valid_ff && verdict.exact;
   assign scan_done = !issue && !cmp_valid_ff;
   assign emit_bit  = hit_mask_ff[emit_idx_ff];
   assign mask_rest = hit_mask_ff & ~(DD'(1) << emit_idx_ff);

   oesc_ram #(
      .WIDTH(oesc_pkg::ROW_W),
      .DEPTH(DD)
   ) u_dict (
      .clock  (clock),
      .wr_en  (store_en),
      .wr_addr(entry_count_ff[IW-1:0]),
      .wr_data(wr_row),
      .rd_en  (issue && !hit_exact),
      .rd_addr(scan_ptr_ff[IW-1:0]),
      .rd_data(rd_row)
   );

   oesc_match u_match (
      .q_letters(word_buf_ff),
      .q_len    (qlen_ff),
      .b_letters(b_letters),
      .b_len    (b_len),
      .result   (verdict)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oesc_pkg::ST_IDLE: begin
            if (word_fin && (act == oesc_pkg::ACT_QUERY) && !final_over) begin
               state_in = oesc_pkg::ST_SCAN;
            end
         end
         oesc_pkg::ST_SCAN: begin
            if (hit_exact) begin
               state_in = oesc_pkg::ST_RESULT;
            end else if (scan_done) begin
               state_in = (hit_mask_ff == '0) ? oesc_pkg::ST_RESULT : oesc_pkg::ST_EMIT;
            end
         end
         oesc_pkg::ST_EMIT: begin
            if (emit_bit && out_free && (mask_rest == '0)) begin
               state_in = oesc_pkg::ST_IDLE;
            end
         end
         oesc_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = oesc_pkg::ST_IDLE;
            end
         end
         default: state_in = oesc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates
   always_comb begin
      entry_count_in = entry_count_ff;
      word_buf_in    = word_buf_ff;
      word_len_in    = word_len_ff;
      overlong_in    = overlong_ff;
      qlen_in        = qlen_ff;
      scan_ptr_in    = scan_ptr_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      hit_mask_in    = hit_mask_ff;
      emit_idx_in    = emit_idx_ff;
      res_status_in  = res_status_ff;
      res_index_in   = res_index_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         oesc_pkg::ST_IDLE: begin
            scan_ptr_in = '0;
            hit_mask_in = '0;
            if (in_fire && (act == oesc_pkg::ACT_CLEAR)) begin
               entry_count_in = '0;
               word_len_in    = '0;
               overlong_in    = 1'b0;
            end else if (in_fire && is_letter) begin
               if (room) begin
                  word_buf_in = row_letters;
                  word_len_in = word_len_ff + LW'(1);
               end else begin
                  overlong_in = 1'b1;
               end
               if (req_tlast) begin
                  word_len_in = '0;
                  overlong_in = 1'b0;
                  qlen_in     = word_len_ff + LW'(1);
                  if (final_over || ((act == oesc_pkg::ACT_LOAD) && dict_full)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = oesc_pkg::STAT_REJECT;
                     rsp_index_in  = '0;
                     rsp_last_in   = 1'b1;
                  end else if (act == oesc_pkg::ACT_LOAD) begin
                     entry_count_in = entry_count_ff + CW'(1);
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = oesc_pkg::STAT_STORED;
                     rsp_index_in   = entry_count_ff[IW-1:0];
                     rsp_last_in    = 1'b1;
                  end
               end
            end
         end
         oesc_pkg::ST_SCAN: begin
            emit_idx_in = '0;
            if (issue) begin
               scan_ptr_in = scan_ptr_ff + CW'(1);
               cmp_idx_in  = scan_ptr_ff[IW-1:0];
            end
            cmp_valid_in = issue && !hit_exact;
            if (hit_exact) begin
               res_status_in = oesc_pkg::STAT_CORRECT;
               res_index_in  = cmp_idx_ff;
            end else if (cmp_valid_ff && verdict.near) begin
               hit_mask_in[cmp_idx_ff] = 1'b1;
            end else if (scan_done) begin
               res_status_in = oesc_pkg::STAT_NOMATCH;
               res_index_in  = '0;
            end
         end
         oesc_pkg::ST_EMIT: begin
            if (!emit_bit) begin
               emit_idx_in = emit_idx_ff + IW'(1);
            end else if (out_free) begin
               emit_idx_in   = emit_idx_ff + IW'(1);
               hit_mask_in   = mask_rest;
               rsp_valid_in  = 1'b1;
               rsp_status_in = oesc_pkg::STAT_SUGGEST;
               rsp_index_in  = emit_idx_ff;
               rsp_last_in   = (mask_rest == '0);
            end
         end
         oesc_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            cmp_valid_in = 1'b0;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= oesc_pkg::ST_IDLE;
         entry_count_ff <= '0;
         word_len_ff    <= '0;
         overlong_ff    <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         word_len_ff    <= word_len_in;
         overlong_ff    <= overlong_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_buf_ff   <= word_buf_in;
      qlen_ff       <= qlen_in;
      scan_ptr_ff   <= scan_ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_mask_ff   <= hit_mask_in;
      emit_idx_ff   <= emit_idx_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(8 - IW)'(0), rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for one_edit_spell_checker: directed table, then random words, checked by a predictor.
module tb;
   import oesc_pkg::*;

   // One result item as the checker sees it
   typedef struct packed {
      status_type          status;
      logic [IDX_W-1:0]    entry;
      logic                last;
   } verdict_t;

   // One row of the directed table; the letter is sent reps times, word_end only on the final one
   typedef struct packed {
      action_type          act;
      logic [LETTER_W-1:0] letter;
      logic                fin;
      logic [4:0]          reps;
      logic                typed;
      status_type          status;
      logic [IDX_W-1:0]    entry;
   } stim_row_t;

   // Edits applied to a stored word to build a near query
   typedef enum logic [1:0] {
      EDIT_KEEP,
      EDIT_SUB,
      EDIT_DEL,
      EDIT_INS
   } edit_kind_t;

   localparam int N_ROWS         = 14;
   localparam int PHASE_ITEMS    = 7;
   localparam int MAX_GAP        = 12;
   localparam int TAIL_CYCLES    = 2 * DICT_DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // Directed rows, some with typed results: after reset, extremes and the reject and no-match codes
   localparam stim_row_t DIRECTED [N_ROWS] = '{
      '{ACT_LOAD,  5'd0,  1'b1, 5'd1, 1'b1, STAT_STORED,  6'd0},
      '{ACT_LOAD,  5'd25, 1'b0, 5'd1, 1'b0, STAT_CORRECT, 6'd0},
      '{ACT_LOAD,  5'd1,  1'b1, 5'd1, 1'b1, STAT_STORED,  6'd1},
      '{ACT_QUERY, 5'd0,  1'b1, 5'd1, 1'b1, STAT_CORRECT, 6'd0},
      '{ACT_QUERY, 5'd2,  1'b1, 5'd1, 1'b0, STAT_CORRECT, 6'd0},
      '{ACT_QUERY, 5'd1,  1'b1, 5'd1, 1'b0, STAT_CORRECT, 6'd0},
      '{ACT_NONE,  5'd31, 1'b1, 5'd1, 1'b0, STAT_CORRECT, 6'd0},
      '{ACT_LOAD,  5'd31, 1'b0, 5'd1, 1'b0, STAT_CORRECT, 6'd0},
      '{ACT_LOAD,  5'd30, 1'b1, 5'd1, 1'b1, STAT_STORED,  6'd2},
      '{ACT_QUERY, 5'd31, 1'b1, 5'd1, 1'b0, STAT_CORRECT, 6'd0},
      // overlong word with mixed actions
      '{ACT_LOAD,  5'd16, 1'b0, 5'd9, 1'b0, STAT_CORRECT, 6'd0},
      '{ACT_QUERY, 5'd31, 1'b1, 5'd8, 1'b1, STAT_REJECT,  6'd0},
      '{ACT_CLEAR, 5'd31, 1'b1, 5'd1, 1'b0, STAT_CORRECT, 6'd0},
      '{ACT_QUERY, 5'd0,  1'b1, 5'd1, 1'b1, STAT_NOMATCH, 6'd0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;       // [4:0] letter
   logic [1:0] req_tuser = ACT_NONE; // [1:0] action
   logic       req_tlast = 1'b0;     // word_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [5:0] entry_index
   logic [2:0] rsp_tuser;            // [2:0] status
   logic       rsp_tlast;            // last

   // Predictor state
   logic [LETTER_W-1:0] dict_letters [DICT_DEPTH][MAX_LEN];
   int unsigned         dict_lengths [DICT_DEPTH];
   int unsigned         entry_cnt = 0;
   logic [LETTER_W-1:0] word_buf [MAX_LEN];
   int unsigned         word_len = 0;
   bit                  word_over = 1'b0;

   verdict_t            verdicts_due [$];
   verdict_t            item_verdicts [$];
   logic [LETTER_W-1:0] word_q [$];

   int send_idle = 38;
   int recv_idle = 57;
   int errors = 0;
   int sent_items = 0;
   int stall_cycles = 0;

   one_edit_spell_checker DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic verdict_t make_verdict(status_type s, int unsigned e, logic last);
      verdict_t v;
      v.status = s;
      v.entry  = e[IDX_W-1:0];
      v.last   = last;
      return v;
   endfunction

   function automatic void note_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   // 2: exact, 1: one edit away, 0: neither; query is word_buf[0..qlen)
   function automatic int near_entry(int unsigned qlen, int unsigned e);
      int unsigned blen, p, i, diffs, dpos;
      blen  = dict_lengths[e];
      diffs = 0;
      dpos  = 0;
      if (qlen == blen) begin
         for (i = 0; i < qlen; i++) begin
            if (word_buf[i] != dict_letters[e][i]) begin
               diffs++;
               dpos = i;
            end
         end
         if (diffs == 0) return 2;
         // substitution only into a real letter
         return (diffs == 1 && dict_letters[e][dpos] < LETTER_W'(ALPHABET)) ? 1 : 0;
      end
      if (qlen == blen + 1) begin
         p = 0;
         while (p < blen && word_buf[p] == dict_letters[e][p]) p++;
         for (i = p; i < blen; i++) begin
            if (word_buf[i+1] != dict_letters[e][i]) return 0;
         end
         return 1;
      end
      if (qlen + 1 == blen) begin
         p = 0;
         while (p < qlen && word_buf[p] == dict_letters[e][p]) p++;
         // inserted letter must be a..z
         if (dict_letters[e][p] >= LETTER_W'(ALPHABET)) return 0;
         for (i = p; i < qlen; i++) begin
            if (dict_letters[e][i+1] != word_buf[i]) return 0;
         end
         return 1;
      end
      return 0;
   endfunction

   // Advance the predictor by one accepted item; results land in item_verdicts
   task automatic score_item(action_type act, logic [LETTER_W-1:0] letter, logic fin);
      int unsigned qlen, e;
      bit          over;
      int          exact, rel;
      verdict_t    v;
      item_verdicts.delete();
      if (act == ACT_NONE) return;
      if (act == ACT_CLEAR) begin
         entry_cnt = 0;
         word_len  = 0;
         word_over = 1'b0;
         return;
      end
      if (word_len < MAX_LEN) begin
         word_buf[word_len] = letter;
         word_len++;
      end else begin
         word_over = 1'b1;
      end
      if (!fin) return;
      qlen      = word_len;
      over      = word_over;
      word_len  = 0;
      word_over = 1'b0;
      exact     = -1;
      if (over) begin
         item_verdicts.push_back(make_verdict(STAT_REJECT, 0, 1'b0));
      end else if (act == ACT_LOAD) begin
         if (entry_cnt >= DICT_DEPTH) begin
            item_verdicts.push_back(make_verdict(STAT_REJECT, 0, 1'b0));
         end else begin
            for (int i = 0; i < qlen; i++) dict_letters[entry_cnt][i] = word_buf[i];
            dict_lengths[entry_cnt] = qlen;
            item_verdicts.push_back(make_verdict(STAT_STORED, entry_cnt, 1'b0));
            entry_cnt++;
         end
      end else begin
         // query: scan in load order, an exact hit wins and stops the scan
         for (e = 0; e < entry_cnt; e++) begin
            rel = near_entry(qlen, e);
            if (rel == 2) begin
               exact = e;
               break;
            end
            if (rel == 1) item_verdicts.push_back(make_verdict(STAT_SUGGEST, e, 1'b0));
         end
         if (exact >= 0) begin
            item_verdicts.delete();
            item_verdicts.push_back(make_verdict(STAT_CORRECT, exact, 1'b0));
         end else if (item_verdicts.size() == 0) begin
            item_verdicts.push_back(make_verdict(STAT_NOMATCH, 0, 1'b0));
         end
      end
      v = item_verdicts.pop_back();
      v.last = 1'b1;
      item_verdicts.push_back(v);
   endtask

   // Drive one item, wait for acceptance, then queue its expected results
   task automatic send_item(action_type act, logic [LETTER_W-1:0] letter, logic fin,
                            bit typed = 1'b0, verdict_t typed_v = '0);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, letter};
      req_tuser  <= act;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      score_item(act, letter, fin);
      if (typed) begin
         verdicts_due.push_back(typed_v);
      end else begin
         foreach (item_verdicts[i]) verdicts_due.push_back(item_verdicts[i]);
      end
      if (act != ACT_NONE) sent_items++;
   endtask

   // Hold the sender until every expected result is in, then let the block settle
   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(4, 1);
      if (r < 93) return $urandom_range(MAX_LEN, 5);
      return $urandom_range(MAX_LEN + 3, MAX_LEN + 1);
   endfunction

   // Small alphabet most of the time so that near words are common
   task automatic build_letters(int unsigned len);
      word_q.delete();
      repeat (len) begin
         if ($urandom_range(99) < 85) word_q.push_back(LETTER_W'($urandom_range(3)));
         else word_q.push_back(LETTER_W'($urandom_range(31)));
      end
   endtask

   // Query built from a stored entry with at most one edit
   task automatic derive_query();
      int unsigned e, pos;
      e = $urandom_range(entry_cnt - 1);
      word_q.delete();
      for (int i = 0; i < dict_lengths[e]; i++) word_q.push_back(dict_letters[e][i]);
      case (edit_kind_t'($urandom_range(3)))
         EDIT_SUB: begin
            pos = $urandom_range(word_q.size() - 1);
            word_q[pos] = ($urandom_range(7) == 0) ? LETTER_W'($urandom_range(31, 26))
                                                    : LETTER_W'($urandom_range(25));
         end
         EDIT_DEL: begin
            if (word_q.size() > 1) word_q.delete($urandom_range(word_q.size() - 1));
         end
         EDIT_INS: begin
            pos = $urandom_range(word_q.size());
            word_q.insert(pos, LETTER_W'($urandom_range(25)));
         end
         default: begin
         end
      endcase
   endtask

   // Send word_q; the final letter carries the deciding action
   task automatic send_word(action_type fin_act);
      action_type other, act;
      other = (fin_act == ACT_LOAD) ? ACT_QUERY : ACT_LOAD;
      for (int i = 0; i < word_q.size(); i++) begin
         if ($urandom_range(99) < 5) begin
            send_item(ACT_NONE, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
         end
         if (i == word_q.size() - 1) begin
            send_item(fin_act, word_q[i], 1'b1);
         end else begin
            act = ($urandom_range(99) < 10) ? other : fin_act;
            send_item(act, word_q[i], 1'b0);
         end
      end
   endtask

   task automatic random_word();
      int r;
      r = $urandom_range(99);
      if (r < 4) begin
         // clear, sometimes dropping a partial word
         if ($urandom_range(1)) begin
            build_letters($urandom_range(3, 1));
            foreach (word_q[i]) send_item($urandom_range(1) ? ACT_QUERY : ACT_LOAD, word_q[i], 1'b0);
         end
         send_item(ACT_CLEAR, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
      end else if (r < 40 || entry_cnt == 0) begin
         build_letters(pick_len());
         send_word(ACT_LOAD);
      end else if (r < 85) begin
         derive_query();
         send_word(ACT_QUERY);
      end else begin
         build_letters(pick_len());
         send_word(ACT_QUERY);
      end
   endtask

   // Fill the store with one-letter words, overflow it, then query a full store
   task automatic fill_store();
      send_item(ACT_CLEAR, 5'd0, 1'b0);
      while (entry_cnt < DICT_DEPTH) send_item(ACT_LOAD, LETTER_W'($urandom_range(25)), 1'b1);
      send_item(ACT_LOAD, 5'd3, 1'b1);
      send_item(ACT_LOAD, 5'd7, 1'b0);
      send_item(ACT_LOAD, 5'd2, 1'b1);
      // every entry is one substitution away: a result per entry
      send_item(ACT_QUERY, 5'd31, 1'b1);
      send_item(ACT_QUERY, LETTER_W'($urandom_range(25)), 1'b0);
      send_item(ACT_QUERY, LETTER_W'($urandom_range(25)), 1'b1);
   endtask

   // Result side: random stalls
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // Compare each result item against the oldest expectation
   always @(posedge clock) begin : result_check
      verdict_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result status=%0d entry=%0d last=%0d",
                                    rsp_tuser, rsp_tdata, rsp_tlast));
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tuser != want.status || rsp_tdata != {2'b00, want.entry} ||
                rsp_tlast != want.last) begin
               note_mismatch($sformatf(
                  "status %0d/%0d entry %0d/%0d last %0d/%0d (expected/actual)",
                  want.status, rsp_tuser, want.entry, rsp_tdata, want.last, rsp_tlast));
            end
         end
      end
   end

   // Watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stimulus
   initial begin
      stim_row_t row;
      int        start;
      logic      at_end;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_ROWS; i++) begin
         row = DIRECTED[i];
         for (int r = 0; r < row.reps; r++) begin
            at_end = (r == row.reps - 1);
            send_item(row.act, row.letter, at_end ? row.fin : 1'b0, row.typed && at_end,
                      make_verdict(row.status, 32'(row.entry), 1'b1));
         end
      end
      wait_results();

      // random words under three idling settings
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 38;
               recv_idle = 57;
            end
            1: begin
               send_idle = 57;
               recv_idle = 38;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         start = sent_items;
         while (sent_items - start < PHASE_ITEMS) random_word();
         if (phase == 1) fill_store();
         wait_results();
      end

      if (errors == 0 && verdicts_due.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
